### sv/twim_pkg.sv
// Shared types and constants for the time-window image matcher.
`timescale 1ns / 1ps

package twim_pkg;

  // Request type codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Command codes passed from the front end to the back end
  localparam logic [1:0] OP_LOAD  = 2'd0;  // store a window
  localparam logic [1:0] OP_SKIP  = 2'd1;  // load to a slot outside the table
  localparam logic [1:0] OP_QUERY = 2'd2;  // scan the table
  localparam logic [1:0] OP_MISS  = 2'd3;  // query with unknown time

  // Window math: span is Q32.16, divided by 100 * 2^16
  localparam int SPAN_W    = 48;
  localparam int PROD_W    = 64;            // whole seconds times the reciprocal
  localparam int QUO_W     = 26;            // whole seconds / 100
  localparam int TRAIL_W   = 24;            // fraction carry compare
  localparam int BEFORE_W  = 27;
  localparam int AFTER_W   = 33;
  localparam logic [22:0] WIN_DENOM   = 23'd6553600;
  localparam logic [6:0]  SCALE_MUL   = 7'd101;
  localparam logic [6:0]  CENT_DIV    = 7'd100;
  // ceil(2^37 / 100): exact floor(x / 100) for any 32-bit x
  localparam logic [31:0] RECIP_MUL   = 32'h51EB_851F;
  localparam int          RECIP_SHIFT = 37;

  // Command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  image_slot;
    logic [31:0] image_start_time;
    logic [31:0] row_rate;
    logic [15:0] row_total;
    logic [31:0] meas_time;
  } twim_in_t;

  typedef struct packed {
    logic       match_found;
    logic [7:0] match_index;
  } twim_out_t;

  // Classified command; tval is t0 for loads and the measurement time for queries
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  slot;
    logic [31:0] tval;
    logic [31:0] rate;
    logic [15:0] rows;
  } twim_cmd_t;

  typedef struct packed {
    logic [31:0] t0;
    logic [31:0] rate;
    logic [15:0] rows;
  } twim_win_req_t;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
  } twim_win_res_t;

endpackage

### sv/twim_front.sv
// Front end: takes input words and classifies them into commands.
`timescale 1ns / 1ps

module twim_front import twim_pkg::*; #(
  parameter int MAX_IMAGES = 256
) (
  input  logic      in_valid,
  output logic      in_ready,
  input  twim_in_t  in_word,
  output logic      push_valid,
  input  logic      push_ready,
  output twim_cmd_t push_data
);

  logic slot_ok;

  // Slots past the table end are dropped but still answered
  assign slot_ok = 32'(in_word.image_slot) < 32'(MAX_IMAGES);

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_data.slot = in_word.image_slot;
    push_data.rate = in_word.row_rate;
    push_data.rows = in_word.row_total;
    case (in_word.req_type)
      REQ_LOAD: begin
        push_data.op   = slot_ok ? OP_LOAD : OP_SKIP;
        push_data.tval = in_word.image_start_time;
      end
      default: begin
        push_data.op   = (in_word.meas_time == 32'd0) ? OP_MISS : OP_QUERY;
        push_data.tval = in_word.meas_time;
      end
    endcase
  end

endmodule

### sv/twim_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module twim_queue import twim_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  twim_cmd_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output twim_cmd_t pop_data
);

  twim_cmd_t              q_mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] fill_r, fill_nxt;
  logic                   push, pop;

  assign push_ready = fill_r != QUEUE_CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = fill_r != '0;
  assign pop_data   = q_mem_r[rd_ptr_r];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  // Pointer and fill tracking
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### sv/twim_window.sv
// Window bounds unit: span multiply, divide by 100*2^16 by reciprocal, saturation.
`timescale 1ns / 1ps

module twim_window import twim_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  twim_win_req_t req,
  output logic          done,
  output twim_win_res_t res
);

  localparam logic [2:0] W_IDLE  = 3'd0;
  localparam logic [2:0] W_MUL   = 3'd1;
  localparam logic [2:0] W_RECIP = 3'd2;
  localparam logic [2:0] W_SPLIT = 3'd3;
  localparam logic [2:0] W_ADJ   = 3'd4;
  localparam logic [2:0] W_END   = 3'd5;

  logic [2:0]          state_r, state_nxt;
  twim_win_req_t       req_r, req_nxt;
  logic [SPAN_W-1:0]   span_r, span_nxt;
  logic [QUO_W-1:0]    quo_r, quo_nxt;     // whole seconds / 100
  logic [6:0]          rem_r, rem_nxt;     // whole seconds mod 100
  logic [BEFORE_W-1:0] before_r, before_nxt;
  logic [AFTER_W-1:0]  after_r, after_nxt;
  logic [31:0]         secs;
  logic [15:0]         frac;
  logic                part_zero;
  logic                trail_carry;
  logic [AFTER_W-1:0]  trail;
  logic [33:0]         hi_sum;

  // Span split into whole seconds and the Q16 fraction
  assign secs = span_r[SPAN_W-1:16];
  assign frac = span_r[15:0];

  // span = D*quo + rem*2^16 + frac, D = 100*2^16
  assign part_zero   = (rem_r == '0) && (frac == '0);
  // floor(101*span/D) = 101*quo + rem + (101*frac + rem*2^16 >= D)
  assign trail_carry = (TRAIL_W'(frac) * TRAIL_W'(SCALE_MUL) + TRAIL_W'({rem_r, 16'd0}))
                       >= TRAIL_W'(WIN_DENOM);
  assign trail       = AFTER_W'(quo_r) * AFTER_W'(SCALE_MUL) + AFTER_W'(rem_r)
                     + AFTER_W'(trail_carry);

  // Final bounds with saturation
  assign hi_sum = 34'(req_r.t0) + 34'(after_r);
  always_comb begin
    res.lo = (req_r.t0 > 32'(before_r)) ? req_r.t0 - 32'(before_r) : 32'd0;
    res.hi = (hi_sum[33:32] != 2'd0) ? 32'hFFFF_FFFF : hi_sum[31:0];
  end
  assign done = state_r == W_END;

  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    span_nxt   = span_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    before_nxt = before_r;
    after_nxt  = after_r;
    case (state_r)
      W_IDLE: begin
        if (start) begin
          req_nxt   = req;
          state_nxt = W_MUL;
        end
      end
      W_MUL: begin
        span_nxt  = SPAN_W'(req_r.rate) * SPAN_W'(req_r.rows);
        state_nxt = W_RECIP;
      end
      W_RECIP: begin
        quo_nxt   = QUO_W'((PROD_W'(secs) * PROD_W'(RECIP_MUL)) >> RECIP_SHIFT);
        state_nxt = W_SPLIT;
      end
      W_SPLIT: begin
        rem_nxt   = 7'(secs - 32'(quo_r) * 32'(CENT_DIV));
        state_nxt = W_ADJ;
      end
      W_ADJ: begin
        // ceil for the lead, floor for the trail, both at least one second
        before_nxt = BEFORE_W'(quo_r) + BEFORE_W'(!part_zero || (quo_r == '0));
        after_nxt  = (trail == '0) ? AFTER_W'(1) : trail;
        state_nxt  = W_END;
      end
      W_END: begin
        state_nxt = W_IDLE;
      end
      default: begin
        state_nxt = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    span_r   <= span_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    before_r <= before_nxt;
    after_r  <= after_nxt;
  end

endmodule

### sv/twim_back.sv
// Back end: window table, load sequencing, in-order query scan and result register.
`timescale 1ns / 1ps

module twim_back import twim_pkg::*; #(
  parameter int MAX_IMAGES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  twim_cmd_t  cmd,
  input  logic [8:0] image_count,
  output logic       out_valid,
  input  logic       out_ready,
  output twim_out_t  out_word
);

  localparam int IW = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
  localparam int CW = $clog2(MAX_IMAGES + 1);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_LOAD  = 2'd1;
  localparam logic [1:0] B_SCAN  = 2'd2;
  localparam logic [1:0] B_REPLY = 2'd3;

  logic [63:0]    win_mem [MAX_IMAGES];   // {lo, hi} per image
  logic [63:0]    rd_data_r;

  logic [1:0]     state_r, state_nxt;
  logic [IW-1:0]  slot_r, slot_nxt;
  logic [31:0]    meas_r, meas_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  issue_r, issue_nxt;
  logic           pend_r, pend_nxt;
  logic [IW-1:0]  pend_idx_r, pend_idx_nxt;
  twim_out_t      res_r, res_nxt;
  logic           out_valid_r, out_valid_nxt;
  twim_out_t      out_word_r, out_word_nxt;

  logic           win_start, win_done;
  twim_win_req_t  win_req;
  twim_win_res_t  win_res;
  logic           mem_we, rd_en, hit;
  logic [CW-1:0]  cnt_sat;

  twim_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .start (win_start),
    .req   (win_req),
    .done  (win_done),
    .res   (win_res)
  );

  assign win_req.t0   = cmd.tval;
  assign win_req.rate = cmd.rate;
  assign win_req.rows = cmd.rows;

  // Search limit never passes the table size
  assign cnt_sat = (32'(image_count) > 32'(MAX_IMAGES)) ? CW'(MAX_IMAGES) : CW'(image_count);

  assign hit = (meas_r >= rd_data_r[63:32]) && (meas_r <= rd_data_r[31:0]);

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    meas_nxt      = meas_r;
    cnt_nxt       = cnt_r;
    issue_nxt     = issue_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_word_nxt  = out_word_r;
    cmd_ready     = 1'b0;
    win_start     = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    case (state_r)
      B_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          res_nxt = '0;
          case (cmd.op)
            OP_LOAD: begin
              win_start = 1'b1;
              slot_nxt  = IW'(cmd.slot);
              state_nxt = B_LOAD;
            end
            OP_QUERY: begin
              meas_nxt  = cmd.tval;
              cnt_nxt   = cnt_sat;
              issue_nxt = '0;
              pend_nxt  = 1'b0;
              state_nxt = (cnt_sat == '0) ? B_REPLY : B_SCAN;
            end
            default: begin
              state_nxt = B_REPLY;
            end
          endcase
        end
      end
      B_LOAD: begin
        if (win_done) begin
          mem_we    = 1'b1;
          state_nxt = B_REPLY;
        end
      end
      B_SCAN: begin
        // Read one entry a cycle; compare it the cycle after
        rd_en        = issue_r < cnt_r;
        issue_nxt    = rd_en ? issue_r + 1'b1 : issue_r;
        pend_nxt     = rd_en;
        pend_idx_nxt = issue_r[IW-1:0];
        if (pend_r) begin
          if (hit) begin
            res_nxt.match_found = 1'b1;
            res_nxt.match_index = 8'(pend_idx_r);
            state_nxt           = B_REPLY;
          end else if (CW'(pend_idx_r) + CW'(1) == cnt_r) begin
            state_nxt = B_REPLY;
          end
        end
      end
      B_REPLY: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_r;
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    meas_r     <= meas_nxt;
    cnt_r      <= cnt_nxt;
    issue_r    <= issue_nxt;
    pend_idx_r <= pend_idx_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  // Window table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[slot_r] <= {win_res.lo, win_res.hi};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= win_mem[issue_r[IW-1:0]];
    end
  end

endmodule

### sv/time_window_image_matcher.sv
// Top level of the time-window image matcher.
//
//   port group   dir   handshake          word
//   in_*         in    in_valid/in_ready  twim_in_t (load or query request)
//   out_*        out   out_valid/out_ready twim_out_t (one result per request)
//   cfg_*        in    cfg_we             9-bit image count
//
// A load passes through the queue, span multiply, reciprocal multiply for the
// divide by 100, remainder, bound adjust, table write and result.
// A query over a nonzero count reads entries in order (count capped at MAX_IMAGES)
// through the single table read port; an empty count answers without a scan.
// A query with unknown time or a dropped load answers without a scan.
// Reset (rst_n low, synchronous) clears control state; table entries stay
// unknown until loaded. The two-entry command queue and the result register
// let input words be taken while a result waits on out_ready.
`timescale 1ns / 1ps

module time_window_image_matcher import twim_pkg::*; #(
  parameter int MAX_IMAGES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  twim_in_t   in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output twim_out_t  out_word,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata
);

  logic [8:0] image_count_q_r, image_count_q_nxt;
  logic       push_valid, push_ready;
  twim_cmd_t  push_data;
  logic       pop_valid, pop_ready;
  twim_cmd_t  pop_data;

  // Image count register
  assign image_count_q_nxt = cfg_we ? cfg_wdata : image_count_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_count_q_r <= '0;
    end else begin
      image_count_q_r <= image_count_q_nxt;
    end
  end

  twim_front #(
    .MAX_IMAGES (MAX_IMAGES)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  twim_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  twim_back #(
    .MAX_IMAGES (MAX_IMAGES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (pop_valid),
    .cmd_ready   (pop_ready),
    .cmd         (pop_data),
    .image_count (image_count_q_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word)
  );

endmodule
